// ===== rtl/fh64_pkg.sv =====
// fh64_pkg: shared types, hash constants and the tail byte mask for fasthash64
// no dependencies; used by fh64_mul and fasthash64_stream
package fh64_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int LEN_W  = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [2:0]        tail_t;

    localparam word_t HASH_M     = 64'h8803_55f2_1e6d_1965;
    localparam word_t MIX_K      = 64'h2127_599b_f432_5c37;
    localparam word_t SEED_RESET = 64'h0004_2133_7f00_beef;
    localparam int    MIX_SHIFT_A = 23;
    localparam int    MIX_SHIFT_B = 47;

    // keeps bytes below tail; a zero tail keeps the whole word
    function automatic word_t tail_mask(input tail_t tail);
        word_t m;
        m = '1;
        for (int i = 1; i < 8; i++) begin
            if (tail == tail_t'(i)) begin
                m = (word_t'(1) << (8 * i)) - word_t'(1);
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/fh64_mul.sv =====
// fh64_mul: 64 x 64 multiply, low 64 bits, on one shared 32 x 32 multiplier
// three partial products; depends on fh64_pkg
module fh64_mul (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  fh64_pkg::word_t op_a,
    input  fh64_pkg::word_t op_b,
    output logic           done,
    output fh64_pkg::word_t product
);
    import fh64_pkg::*;

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    logic       busy_reg, busy_next;
    logic [1:0] step_reg, step_next;
    logic       pv_reg, pv_next;
    logic [1:0] pstep_reg, pstep_next;
    word_t      prod_reg, prod_next;
    word_t      acc_reg, acc_next;
    logic       done_reg, done_next;
    half_t      sel_a, sel_b;

    // operands must stay stable from start until done; the block itself does not enforce this
    always_comb begin
        unique case (step_reg)
            STEP_LL: begin
                sel_a = op_a[HALF_W-1:0];
                sel_b = op_b[HALF_W-1:0];
            end
            STEP_LH: begin
                sel_a = op_a[HALF_W-1:0];
                sel_b = op_b[WORD_W-1:HALF_W];
            end
            STEP_HL: begin
                sel_a = op_a[WORD_W-1:HALF_W];
                sel_b = op_b[HALF_W-1:0];
            end
            default: begin
                sel_a = '0;
                sel_b = '0;
            end
        endcase
    end

    always_comb begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        prod_next  = word_t'(sel_a) * word_t'(sel_b);
        pstep_next = step_reg;
        pv_next    = busy_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_LL;
        end else if (busy_reg) begin
            step_next = step_reg + 2'd1;
            if (step_reg == STEP_HL) begin
                busy_next = 1'b0;
            end
        end
        // cross products only reach the upper half
        if (pv_reg) begin
            if (pstep_reg == STEP_LL) begin
                acc_next = prod_reg;
            end else begin
                acc_next = acc_reg + {prod_reg[HALF_W-1:0], half_t'(0)};
            end
            done_next = (pstep_reg == STEP_HL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            step_reg  <= STEP_LL;
            pv_reg    <= 1'b0;
            pstep_reg <= STEP_LL;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            pv_reg    <= pv_next;
            pstep_reg <= pstep_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg && !pv_reg)
        else $error("multiply started while one is in flight");
    a_done_after_hl: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(pv_reg) && $past(pstep_reg) == STEP_HL)
        else $error("multiply done without final partial product");
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg != 2'd3)
        else $error("multiply step out of range");

endmodule

// ===== rtl/fasthash64_stream.sv =====
// fasthash64_stream: streaming fasthash64 over little-endian 64-bit words
// sequencer around one shared multiplier fh64_mul; depends on fh64_pkg
// each 64-bit multiply runs on the shared 32 x 32 multiplier
// a word goes from accept to ready again through accept, mix setup, then two multiplies
// a first item adds a seed setup multiply, a last item adds the final mix and output load
// an empty message skips the word mix; m_valid rises as ready returns
// ready drops while an item is in work; a finished hash waits in the output register
// synchronous active-low reset clears the hash state and restores the default seed
module fasthash64_stream (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  fh64_pkg::word_t cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  fh64_pkg::word_t s_data_word,
    input  logic            s_first,
    input  logic            s_last,
    input  fh64_pkg::len_t  s_message_length,
    output logic            m_valid,
    input  logic            m_ready,
    output fh64_pkg::word_t m_hash_value
);
    import fh64_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_INIT_W = 7'b0000010,
        ST_MIXA   = 7'b0000100,
        ST_MIXA_W = 7'b0001000,
        ST_ABS_W  = 7'b0010000,
        ST_FIN_W  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    word_t  seed_reg;
    word_t  hash_reg, hash_next;
    tail_t  tail_reg, tail_next;
    logic   empty_reg, empty_next;
    word_t  word_reg, word_next;
    logic   last_reg, last_next;
    word_t  mul_a_reg, mul_a_next;
    word_t  mul_b_reg, mul_b_next;
    logic   mul_start_reg, mul_start_next;
    logic   out_valid_reg, out_valid_next;
    word_t  out_hash_reg, out_hash_next;

    logic   mul_done;
    word_t  mul_product;
    word_t  masked_word;

    fh64_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    assign masked_word = last_reg ? (word_reg & tail_mask(tail_reg)) : word_reg;

    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_start_next = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        out_hash_next  = out_hash_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    word_next = s_data_word;
                    last_next = s_last;
                    if (s_first) begin
                        tail_next      = s_message_length[2:0];
                        empty_next     = (s_message_length == '0);
                        mul_a_next     = word_t'(s_message_length);
                        mul_b_next     = HASH_M;
                        mul_start_next = 1'b1;
                        state_next     = ST_INIT_W;
                    end else begin
                        state_next = ST_MIXA;
                    end
                end
            end
            ST_INIT_W: begin
                if (mul_done) begin
                    hash_next  = seed_reg ^ mul_product;
                    state_next = ST_MIXA;
                end
            end
            ST_MIXA: begin
                if (!empty_reg) begin
                    mul_a_next     = masked_word ^ (masked_word >> MIX_SHIFT_A);
                    mul_b_next     = MIX_K;
                    mul_start_next = 1'b1;
                    state_next     = ST_MIXA_W;
                end else if (last_reg) begin
                    // empty message goes straight to the final mix
                    mul_a_next     = hash_reg ^ (hash_reg >> MIX_SHIFT_A);
                    mul_b_next     = MIX_K;
                    mul_start_next = 1'b1;
                    state_next     = ST_FIN_W;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MIXA_W: begin
                if (mul_done) begin
                    mul_a_next     = hash_reg ^ mul_product ^ (mul_product >> MIX_SHIFT_B);
                    mul_b_next     = HASH_M;
                    mul_start_next = 1'b1;
                    state_next     = ST_ABS_W;
                end
            end
            ST_ABS_W: begin
                if (mul_done) begin
                    hash_next = mul_product;
                    if (last_reg) begin
                        mul_a_next     = mul_product ^ (mul_product >> MIX_SHIFT_A);
                        mul_b_next     = MIX_K;
                        mul_start_next = 1'b1;
                        state_next     = ST_FIN_W;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN_W: begin
                if (mul_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // product holds until the next start
                if (!out_valid_reg || m_ready) begin
                    out_hash_next  = mul_product ^ (mul_product >> MIX_SHIFT_B);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seed_reg      <= SEED_RESET;
            hash_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b0;
            last_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            last_reg      <= last_next;
            mul_start_reg <= mul_start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        out_hash_reg <= out_hash_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;

    a_no_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !mul_done)
        else $error("multiply finished with no item in work");
    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result shown without final mix");
    a_first_init: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_first |=> state_reg == ST_INIT_W && mul_start_reg)
        else $error("first item did not start seed setup");
    a_start_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start_reg |-> state_reg == ST_INIT_W || state_reg == ST_MIXA_W ||
                          state_reg == ST_ABS_W || state_reg == ST_FIN_W)
        else $error("multiply started outside a wait state");

endmodule
